// ===== rtl/npp_pkg.sv =====
`default_nettype none

package npp_pkg;

   // Shared multiplier operand and product widths
   localparam int MA_W = 38;
   localparam int MB_W = 22;
   localparam int MP_W = MA_W + MB_W;

   localparam int STEP_W = 5;

   // Multiplier issue slots of the per-item sequence
   localparam logic [STEP_W-1:0] MS_PX   = 5'd0;
   localparam logic [STEP_W-1:0] MS_PY   = 5'd1;
   localparam logic [STEP_W-1:0] MS_PZ   = 5'd2;
   localparam logic [STEP_W-1:0] MS_MX   = 5'd3;
   localparam logic [STEP_W-1:0] MS_MY   = 5'd4;
   localparam logic [STEP_W-1:0] MS_MZ   = 5'd5;
   localparam logic [STEP_W-1:0] MS_DL   = 5'd6;
   localparam logic [STEP_W-1:0] MS_DH   = 5'd7;
   localparam logic [STEP_W-1:0] MS_CC   = 5'd8;
   localparam logic [STEP_W-1:0] MS_QX   = 5'd9;
   localparam logic [STEP_W-1:0] MS_QY   = 5'd10;
   localparam logic [STEP_W-1:0] MS_QZ   = 5'd11;
   localparam logic [STEP_W-1:0] MS_W00  = 5'd12;
   localparam logic [STEP_W-1:0] MS_W01  = 5'd13;
   localparam logic [STEP_W-1:0] MS_W10  = 5'd14;
   localparam logic [STEP_W-1:0] MS_W11  = 5'd15;
   localparam logic [STEP_W-1:0] MS_LAST = MS_W11;
   // Non-multiply sequencer points
   localparam logic [STEP_W-1:0] ST_D16  = 5'd4;
   localparam logic [STEP_W-1:0] ST_C16  = 5'd7;
   localparam logic [STEP_W-1:0] ST_FIN  = 5'd17;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [17:0] mx;
      logic signed [17:0] my;
      logic signed [17:0] mz;
      logic signed [17:0] nx;
      logic signed [17:0] ny;
      logic signed [17:0] nz;
      logic signed [31:0] d;
      logic               last;
   } item_type;

   typedef struct packed {
      logic signed [31:0] qx;
      logic signed [31:0] qy;
      logic signed [31:0] qz;
      logic [63:0]        score;
      logic               last;
   } res_type;

   typedef struct packed {
      logic busy;
      logic fin;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/npp_mul.sv =====
`default_nettype none

module npp_mul (
   input  wire logic                              clock,
   input  wire logic signed [npp_pkg::MA_W-1:0]   mul_a,
   input  wire logic signed [npp_pkg::MB_W-1:0]   mul_b,
   output logic signed      [npp_pkg::MP_W-1:0]   prod_ff
);
   import npp_pkg::*;

   always_ff @(posedge clock) begin
      prod_ff <= MP_W'(mul_a * mul_b);
   end

endmodule

`default_nettype wire

// ===== rtl/npp_core.sv =====
`default_nettype none

module npp_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire npp_pkg::item_type  item,
   input  wire logic               fin_ack,
   output npp_pkg::stat_type       stat,
   output npp_pkg::res_type        res
);
   import npp_pkg::*;

   localparam logic [52:0]  D16_RND = 53'd32769;   // 2^15 + 1 folds the negate
   localparam logic [37:0]  C16_RND = 38'd32768;
   localparam logic [55:0]  Q_RND   = 56'd32768;
   localparam logic [32:0]  W_ONE   = 33'h1_0000_0000;

   logic                     busy_ff;
   logic [STEP_W-1:0]        st_ff;
   logic                     pvld_ff;
   logic [STEP_W-1:0]        ptag_ff;
   item_type                 item_ff;
   logic signed [52:0]       sacc_ff;
   logic signed [36:0]       cacc_ff;
   logic signed [36:0]       d16_ff;
   logic signed [21:0]       c16_ff;
   logic signed [71:0]       a2_ff;
   logic [32:0]              w_ff;
   logic [104:0]             sc_ff;
   logic signed [31:0]       qx_ff;
   logic signed [31:0]       qy_ff;
   logic signed [31:0]       qz_ff;

   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [MP_W-1:0]   prod_ff;
   logic [52:0]              d16_sum;
   logic [37:0]              c16_sum;

   function automatic logic signed [31:0] proj_sat(
      input logic signed [31:0]     p,
      input logic signed [MP_W-1:0] pr
   );
      logic signed [55:0] sum;
      logic signed [39:0] v;
      begin
         sum = (56'(p) <<< 16) + 56'(pr) + Q_RND;
         v   = sum[55:16];
         if (v[39:31] != {9{v[39]}}) begin
            proj_sat = v[39] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end else begin
            proj_sat = v[31:0];
         end
      end
   endfunction

   npp_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // operand select per issue slot
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (st_ff)
         MS_PX: begin mul_a = MA_W'(item_ff.px); mul_b = MB_W'(item_ff.nx); end
         MS_PY: begin mul_a = MA_W'(item_ff.py); mul_b = MB_W'(item_ff.ny); end
         MS_PZ: begin mul_a = MA_W'(item_ff.pz); mul_b = MB_W'(item_ff.nz); end
         MS_MX: begin mul_a = MA_W'(item_ff.mx); mul_b = MB_W'(item_ff.nx); end
         MS_MY: begin mul_a = MA_W'(item_ff.my); mul_b = MB_W'(item_ff.ny); end
         MS_MZ: begin mul_a = MA_W'(item_ff.mz); mul_b = MB_W'(item_ff.nz); end
         MS_DL: begin
            mul_a = MA_W'(d16_ff);
            mul_b = MB_W'({1'b0, d16_ff[17:0]});
         end
         MS_DH: begin
            mul_a = MA_W'(d16_ff);
            mul_b = MB_W'($signed(d16_ff[36:18]));
         end
         MS_CC: begin mul_a = MA_W'(c16_ff); mul_b = c16_ff; end
         MS_QX: begin mul_a = MA_W'(d16_ff); mul_b = MB_W'(item_ff.nx); end
         MS_QY: begin mul_a = MA_W'(d16_ff); mul_b = MB_W'(item_ff.ny); end
         MS_QZ: begin mul_a = MA_W'(d16_ff); mul_b = MB_W'(item_ff.nz); end
         MS_W00: begin
            mul_a = MA_W'({1'b0, a2_ff[36:0]});
            mul_b = MB_W'({1'b0, w_ff[20:0]});
         end
         MS_W01: begin
            mul_a = MA_W'({1'b0, a2_ff[36:0]});
            mul_b = MB_W'({1'b0, w_ff[32:21]});
         end
         MS_W10: begin
            mul_a = MA_W'({1'b0, a2_ff[70:37]});
            mul_b = MB_W'({1'b0, w_ff[20:0]});
         end
         MS_W11: begin
            mul_a = MA_W'({1'b0, a2_ff[70:37]});
            mul_b = MB_W'({1'b0, w_ff[32:21]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign d16_sum = ~sacc_ff + D16_RND;
   assign c16_sum = 38'(cacc_ff) + C16_RND;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         st_ff   <= '0;
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= busy_ff && (st_ff <= MS_LAST);
         if (start) begin
            busy_ff <= 1'b1;
            st_ff   <= '0;
         end else if (busy_ff) begin
            if (st_ff == ST_FIN) begin
               if (fin_ack) begin
                  busy_ff <= 1'b0;
               end
            end else begin
               st_ff <= st_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ptag_ff <= st_ff;
      if (start) begin
         item_ff <= item;
         sacc_ff <= 53'(item.d) <<< 16;
         cacc_ff <= '0;
         sc_ff   <= '0;
      end else begin
         if (busy_ff && st_ff == ST_D16) begin
            d16_ff <= $signed(d16_sum[52:16]);
         end
         if (busy_ff && st_ff == ST_C16) begin
            c16_ff <= $signed(c16_sum[37:16]);
         end
         if (pvld_ff) begin
            unique case (ptag_ff) inside
               MS_PX, MS_PY, MS_PZ: sacc_ff <= sacc_ff + $signed(prod_ff[52:0]);
               MS_MX, MS_MY, MS_MZ: cacc_ff <= cacc_ff + $signed(prod_ff[36:0]);
               MS_DL: a2_ff <= 72'(prod_ff);
               MS_DH: a2_ff <= a2_ff + (72'(prod_ff) <<< 18);
               MS_CC: begin
                  if (prod_ff[40:32] != 9'd0) begin
                     w_ff <= '0;
                  end else begin
                     w_ff <= W_ONE - 33'(prod_ff[31:0]);
                  end
               end
               MS_QX: qx_ff <= proj_sat(item_ff.px, prod_ff);
               MS_QY: qy_ff <= proj_sat(item_ff.py, prod_ff);
               MS_QZ: qz_ff <= proj_sat(item_ff.pz, prod_ff);
               MS_W00: sc_ff <= sc_ff + 105'(prod_ff[58:0]);
               MS_W01: sc_ff <= sc_ff + (105'(prod_ff[58:0]) << 21);
               MS_W10: sc_ff <= sc_ff + (105'(prod_ff[58:0]) << 37);
               MS_W11: sc_ff <= sc_ff + (105'(prod_ff[58:0]) << 58);
               default: ;
            endcase
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.fin  = busy_ff && (st_ff == ST_FIN);

   assign res.qx    = qx_ff;
   assign res.qy    = qy_ff;
   assign res.qz    = qz_ff;
   assign res.score = (sc_ff[104:96] != 9'd0) ? '1 : sc_ff[95:32];
   assign res.last  = item_ff.last;

endmodule

`default_nettype wire

// ===== rtl/nearest_plane_point_projection_unit.sv =====
`default_nettype none
// A result transfer is offered from the output register after the finish step of its run.
// Items are taken only while the sequencer is idle; all sixteen products of an item pass
// through the single 38 x 22 multiplier, one per cycle, followed by the score finish step.
// Reset (synchronous, active high) idles the sequencer, drops any pending result and sets
// the running best to the origin with an all-ones score.

module nearest_plane_point_projection_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // point_x, point_y, point_z, normal_x, normal_y, normal_z,
   // plane_nx, plane_ny, plane_nz, plane_offset, 4 zero pad bits
   input  wire logic [239:0]  req_tdata,
   input  wire logic          req_tlast,     // last_plane
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // moved_x, moved_y, moved_z, best_score
   output logic [159:0]       rsp_tdata
);
   import npp_pkg::*;

   item_type            item;
   res_type             res;
   stat_type            stat;
   logic                start;
   logic                fin_ack;
   logic                better;

   logic signed [31:0]  best_x_ff;
   logic signed [31:0]  best_y_ff;
   logic signed [31:0]  best_z_ff;
   logic [63:0]         best_score_ff;
   logic signed [31:0]  nb_x;
   logic signed [31:0]  nb_y;
   logic signed [31:0]  nb_z;
   logic [63:0]         nb_score;

   logic                rsp_valid_ff;
   logic [159:0]        rsp_data_ff;

   // unpack the input transfer
   assign item.px   = req_tdata[31:0];
   assign item.py   = req_tdata[63:32];
   assign item.pz   = req_tdata[95:64];
   assign item.mx   = req_tdata[113:96];
   assign item.my   = req_tdata[131:114];
   assign item.mz   = req_tdata[149:132];
   assign item.nx   = req_tdata[167:150];
   assign item.ny   = req_tdata[185:168];
   assign item.nz   = req_tdata[203:186];
   assign item.d    = req_tdata[235:204];
   assign item.last = req_tlast;

   // take a new item only while the sequencer is free
   assign req_tready = !stat.busy;
   assign start      = req_tvalid && req_tready;

   // hold the finish step while a run ends and the output register is still occupied
   assign fin_ack = !res.last || !rsp_valid_ff || rsp_tready;

   npp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .item    (item),
      .fin_ack (fin_ack),
      .stat    (stat),
      .res     (res)
   );

   // a later plane wins only on a strictly lower score, so ties keep the earlier plane
   assign better = res.score < best_score_ff;

   always_comb begin
      if (better) begin
         nb_x     = res.qx;
         nb_y     = res.qy;
         nb_z     = res.qz;
         nb_score = res.score;
      end else begin
         nb_x     = best_x_ff;
         nb_y     = best_y_ff;
         nb_z     = best_z_ff;
         nb_score = best_score_ff;
      end
   end

   // running best: update per plane, clear after the last plane of a run
   always_ff @(posedge clock) begin
      if (reset) begin
         best_x_ff     <= '0;
         best_y_ff     <= '0;
         best_z_ff     <= '0;
         best_score_ff <= '1;
      end else if (stat.fin && fin_ack) begin
         if (res.last) begin
            best_x_ff     <= '0;
            best_y_ff     <= '0;
            best_z_ff     <= '0;
            best_score_ff <= '1;
         end else begin
            best_x_ff     <= nb_x;
            best_y_ff     <= nb_y;
            best_z_ff     <= nb_z;
            best_score_ff <= nb_score;
         end
      end
   end

   // output register: load the winner at the end of a run, drop it once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.fin && fin_ack && res.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.fin && fin_ack && res.last) begin
         rsp_data_ff <= {nb_score, nb_z, nb_y, nb_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
